FILE: rtl/bmm_pkg.sv
// bmm_pkg: shared types, codes and constants of the banked memory mapper
// used by the core, the modulo unit and the port checker; no dependencies

package bmm_pkg;

   // request operation codes
   localparam logic [1:0] OP_READ      = 2'd0;
   localparam logic [1:0] OP_WRITE     = 2'd1;
   localparam logic [1:0] OP_MAP_RESET = 2'd2;
   // spare code, ignored by the core
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   // target memory codes
   localparam logic [1:0] TGT_RAM  = 2'd0;
   localparam logic [1:0] TGT_CART = 2'd1;
   localparam logic [1:0] TGT_SRAM = 2'd2;
   localparam logic [1:0] TGT_OPEN = 2'd3;

   // field widths
   localparam int OP_W    = 2;
   localparam int ADDR_W  = 16;
   localparam int DATA_W  = 8;
   localparam int PHYS_W  = 20;
   localparam int TGT_W   = 2;
   localparam int BLK_W   = 8;
   localparam int OFF_W   = 13;
   localparam int SLOTS   = 8;
   localparam int STEP_W  = $clog2(DATA_W);

   // frame register decode
   localparam logic [ADDR_W-1:0] MAPPER_BASE = 16'hFFFC;
   localparam int SRAM_ON_BIT   = 3;
   localparam int SRAM_BANK_BIT = 2;
   localparam logic [DATA_W-1:0] MIN_PAGES = 8'd4;

   // frame register indexes
   localparam logic [1:0] REG_CTRL  = 2'd0;
   localparam logic [1:0] REG_PAGE0 = 2'd1;
   localparam logic [1:0] REG_PAGE1 = 2'd2;
   localparam logic [1:0] REG_PAGE2 = 2'd3;

   // parameter defaults
   localparam int CART_BLOCKS_MAX_DEF = 128;
   localparam int SRAM_BYTES_DEF      = 32768;

   // modulo unit control and status
   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] dividend;
      logic [DATA_W-1:0] divisor;
   } mod_ctrl_type;

   typedef struct packed {
      logic              done;
      logic [DATA_W-1:0] rem;
   } mod_stat_type;

endpackage

FILE: rtl/bmm_mod_unit.sv
// bmm_mod_unit: iterative restoring remainder, one dividend bit per cycle
// depends on bmm_pkg for widths and the control/status structs

module bmm_mod_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  bmm_pkg::mod_ctrl_type ctrl,
   output bmm_pkg::mod_stat_type stat
);

   logic                          busy_ff, busy_in;
   logic [bmm_pkg::STEP_W-1:0]    cnt_ff, cnt_in;
   logic [bmm_pkg::DATA_W-1:0]    rem_ff, rem_in;
   logic [bmm_pkg::DATA_W-1:0]    dvd_ff, dvd_in;
   logic [bmm_pkg::DATA_W-1:0]    div_ff, div_in;
   logic [bmm_pkg::DATA_W:0]      shifted;
   logic [bmm_pkg::DATA_W:0]      trial;
   logic                          last_step;

   // one shift and compare-subtract step
   always_comb begin
      shifted   = {rem_ff, dvd_ff[bmm_pkg::DATA_W-1]};
      trial     = shifted - {1'b0, div_ff};
      last_step = busy_ff && (cnt_ff == {bmm_pkg::STEP_W{1'b1}});
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      dvd_in    = dvd_ff;
      div_in    = div_ff;
      if (ctrl.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = ctrl.dividend;
         div_in  = ctrl.divisor;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, div_ff}) begin
            rem_in = trial[bmm_pkg::DATA_W-1:0];
         end else begin
            rem_in = shifted[bmm_pkg::DATA_W-1:0];
         end
         dvd_in = {dvd_ff[bmm_pkg::DATA_W-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (last_step) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
   end

   // remainder is final in the cycle of the last step
   assign stat.done = last_step;
   assign stat.rem  = rem_in;

endmodule

FILE: rtl/banked_memory_mapper_core.sv
// banked_memory_mapper_core: bus address translation through eight 8K slots
// depends on bmm_pkg and bmm_mod_unit
//
//   channel  ports                            direction  handshake
//   request  req_op/cpu_address/write_data    in         req_valid, req_stall
//   response rsp_target/phys_address/...      out        rsp_valid, rsp_stall
//   config   csr_write_data                   in         csr_write_enable
//
// read, write and map reset: response registered in the cycle after acceptance
// frame register write: response registered in the cycle after acceptance, then
//   requests stall while the shared modulo unit works out the page, one dividend bit per cycle
// reset (synchronous) restores the power-on map; no clearing pass
// a waiting response holds the request side only when the new one cannot land

module banked_memory_mapper_core #(
   parameter int CART_BLOCKS_MAX = bmm_pkg::CART_BLOCKS_MAX_DEF,
   parameter int SRAM_BYTES      = bmm_pkg::SRAM_BYTES_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [bmm_pkg::OP_W-1:0]    req_op,
   input  logic [bmm_pkg::ADDR_W-1:0]  req_cpu_address,
   input  logic [bmm_pkg::DATA_W-1:0]  req_write_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [bmm_pkg::TGT_W-1:0]   rsp_target,
   output logic [bmm_pkg::PHYS_W-1:0]  rsp_phys_address,
   output logic                        rsp_write_enable,
   output logic                        rsp_mapper_updated,
   input  logic                        csr_write_enable,
   input  logic [bmm_pkg::DATA_W-1:0]  csr_write_data
);

   localparam logic [0:0] ST_IDLE = 1'b0;
   localparam logic [0:0] ST_MOD  = 1'b1;

   localparam logic [bmm_pkg::DATA_W:0] CART_MAX = (bmm_pkg::DATA_W+1)'(CART_BLOCKS_MAX);
   localparam logic [15:0]              SRAM_LIM = 16'(SRAM_BYTES);

   // save ram addresses wrap at its size (input below twice the size)
   function automatic logic [bmm_pkg::PHYS_W-1:0] sram_wrap(input logic [14:0] a);
      logic [15:0] diff;
      diff = {1'b0, a} - SRAM_LIM;
      if ({1'b0, a} >= SRAM_LIM) begin
         return bmm_pkg::PHYS_W'(diff);
      end
      return bmm_pkg::PHYS_W'(a);
   endfunction

   logic [0:0]                   state_ff, state_in;
   logic [bmm_pkg::DATA_W-1:0]   cart_blocks_ff;
   logic [bmm_pkg::TGT_W-1:0]    slot_kind_ff [bmm_pkg::SLOTS];
   logic [bmm_pkg::TGT_W-1:0]    slot_kind_in [bmm_pkg::SLOTS];
   logic [bmm_pkg::BLK_W-1:0]    slot_blk_ff  [bmm_pkg::SLOTS];
   logic [bmm_pkg::BLK_W-1:0]    slot_blk_in  [bmm_pkg::SLOTS];
   logic [bmm_pkg::DATA_W-1:0]   frame_ff [4];
   logic [bmm_pkg::DATA_W-1:0]   frame_in [4];
   logic [1:0]                   upd_reg_ff, upd_reg_in;
   logic [bmm_pkg::DATA_W-1:0]   upd_data_ff, upd_data_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [bmm_pkg::TGT_W-1:0]    rsp_target_ff, rsp_target_in;
   logic [bmm_pkg::PHYS_W-1:0]   rsp_phys_ff, rsp_phys_in;
   logic                         rsp_we_ff, rsp_we_in;
   logic                         rsp_upd_ff, rsp_upd_in;

   logic                         out_free;
   logic                         accept;
   logic [bmm_pkg::DATA_W:0]     eff_blocks;
   logic [bmm_pkg::DATA_W-1:0]   pages;
   logic [2:0]                   slot;
   logic [bmm_pkg::OFF_W-1:0]    off;
   logic [bmm_pkg::BLK_W+bmm_pkg::OFF_W-1:0] rd_full;
   logic                         mapper_hit;
   logic [6:0]                   page;
   bmm_pkg::mod_ctrl_type        mod_ctrl;
   bmm_pkg::mod_stat_type        mod_stat;

   // handshake
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   // effective cartridge size and page count
   always_comb begin
      if ({1'b0, cart_blocks_ff} > CART_MAX) begin
         eff_blocks = CART_MAX;
      end else begin
         eff_blocks = {1'b0, cart_blocks_ff};
      end
      pages = eff_blocks[bmm_pkg::DATA_W:1];
   end

   assign slot       = req_cpu_address[15:13];
   assign off        = req_cpu_address[bmm_pkg::OFF_W-1:0];
   assign rd_full    = {slot_blk_ff[slot], off};
   assign mapper_hit = (pages >= bmm_pkg::MIN_PAGES)
                       && (req_cpu_address >= bmm_pkg::MAPPER_BASE);
   assign page       = mod_stat.rem[6:0];

   // response of the accepted request, taken through the map before update
   always_comb begin
      rsp_target_in = bmm_pkg::TGT_RAM;
      rsp_phys_in   = '0;
      rsp_we_in     = 1'b0;
      rsp_upd_in    = 1'b0;
      unique case (req_op)
         bmm_pkg::OP_READ: begin
            rsp_target_in = slot_kind_ff[slot];
            case (slot_kind_ff[slot])
               bmm_pkg::TGT_OPEN: rsp_phys_in = '0;
               bmm_pkg::TGT_SRAM: rsp_phys_in = sram_wrap(rd_full[14:0]);
               default:           rsp_phys_in = rd_full[bmm_pkg::PHYS_W-1:0];
            endcase
         end
         bmm_pkg::OP_WRITE: begin
            if ((slot[2:1] == 2'b10) && frame_ff[0][bmm_pkg::SRAM_ON_BIT]) begin
               rsp_target_in = bmm_pkg::TGT_SRAM;
               rsp_phys_in   = sram_wrap({frame_ff[0][bmm_pkg::SRAM_BANK_BIT],
                                          slot[0], off});
            end else begin
               rsp_target_in = bmm_pkg::TGT_RAM;
               rsp_phys_in   = bmm_pkg::PHYS_W'(req_cpu_address);
            end
            rsp_we_in  = 1'b1;
            rsp_upd_in = mapper_hit;
         end
         default: begin
         end
      endcase
   end

   // modulo unit start: register 0 needs frame register 3, others the data
   always_comb begin
      mod_ctrl.start    = accept && (req_op == bmm_pkg::OP_WRITE) && mapper_hit;
      mod_ctrl.divisor  = pages;
      if (req_cpu_address[1:0] == bmm_pkg::REG_CTRL) begin
         mod_ctrl.dividend = frame_ff[3];
      end else begin
         mod_ctrl.dividend = req_write_data;
      end
   end

   bmm_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .ctrl  (mod_ctrl),
      .stat  (mod_stat)
   );

   // sequencer, map reset and frame register update
   always_comb begin
      state_in    = state_ff;
      upd_reg_in  = upd_reg_ff;
      upd_data_in = upd_data_ff;
      slot_kind_in = slot_kind_ff;
      slot_blk_in  = slot_blk_ff;
      frame_in     = frame_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               if (mod_ctrl.start) begin
                  state_in    = ST_MOD;
                  upd_reg_in  = req_cpu_address[1:0];
                  upd_data_in = req_write_data;
               end
               if (req_op == bmm_pkg::OP_MAP_RESET) begin
                  for (int s = 0; s < 4; s++) begin
                     if (eff_blocks > (bmm_pkg::DATA_W+1)'(s)) begin
                        slot_kind_in[s] = bmm_pkg::TGT_CART;
                        slot_blk_in[s]  = bmm_pkg::BLK_W'(s);
                     end else begin
                        slot_kind_in[s] = bmm_pkg::TGT_OPEN;
                        slot_blk_in[s]  = '0;
                     end
                  end
                  for (int s = 4; s < 6; s++) begin
                     if (eff_blocks > (bmm_pkg::DATA_W+1)'(s)) begin
                        slot_kind_in[s] = bmm_pkg::TGT_CART;
                     end else begin
                        slot_kind_in[s] = bmm_pkg::TGT_RAM;
                     end
                     slot_blk_in[s] = bmm_pkg::BLK_W'(s);
                  end
                  for (int s = 6; s < 8; s++) begin
                     slot_kind_in[s] = bmm_pkg::TGT_RAM;
                     slot_blk_in[s]  = bmm_pkg::BLK_W'(s);
                  end
                  frame_in[0] = 8'd0;
                  frame_in[1] = 8'd0;
                  frame_in[2] = 8'd1;
                  frame_in[3] = 8'd0;
               end
            end
         end
         ST_MOD: begin
            if (mod_stat.done) begin
               state_in           = ST_IDLE;
               frame_in[upd_reg_ff] = upd_data_ff;
               unique case (upd_reg_ff)
                  bmm_pkg::REG_CTRL: begin
                     if (upd_data_ff[bmm_pkg::SRAM_ON_BIT]) begin
                        slot_kind_in[4] = bmm_pkg::TGT_SRAM;
                        slot_kind_in[5] = bmm_pkg::TGT_SRAM;
                        slot_blk_in[4]  = {6'd0, upd_data_ff[bmm_pkg::SRAM_BANK_BIT], 1'b0};
                        slot_blk_in[5]  = {6'd0, upd_data_ff[bmm_pkg::SRAM_BANK_BIT], 1'b1};
                     end else begin
                        slot_kind_in[4] = bmm_pkg::TGT_CART;
                        slot_kind_in[5] = bmm_pkg::TGT_CART;
                        slot_blk_in[4]  = {page, 1'b0};
                        slot_blk_in[5]  = {page, 1'b1};
                     end
                  end
                  bmm_pkg::REG_PAGE0: begin
                     slot_kind_in[0] = bmm_pkg::TGT_CART;
                     slot_kind_in[1] = bmm_pkg::TGT_CART;
                     slot_blk_in[0]  = {page, 1'b0};
                     slot_blk_in[1]  = {page, 1'b1};
                  end
                  bmm_pkg::REG_PAGE1: begin
                     slot_kind_in[2] = bmm_pkg::TGT_CART;
                     slot_kind_in[3] = bmm_pkg::TGT_CART;
                     slot_blk_in[2]  = {page, 1'b0};
                     slot_blk_in[3]  = {page, 1'b1};
                  end
                  bmm_pkg::REG_PAGE2: begin
                     if (!frame_ff[0][bmm_pkg::SRAM_ON_BIT]) begin
                        slot_kind_in[4] = bmm_pkg::TGT_CART;
                        slot_kind_in[5] = bmm_pkg::TGT_CART;
                        slot_blk_in[4]  = {page, 1'b0};
                        slot_blk_in[5]  = {page, 1'b1};
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and map state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         cart_blocks_ff <= '0;
         for (int s = 0; s < bmm_pkg::SLOTS; s++) begin
            slot_kind_ff[s] <= bmm_pkg::TGT_RAM;
            slot_blk_ff[s]  <= bmm_pkg::BLK_W'(s);
         end
         frame_ff[0] <= 8'd0;
         frame_ff[1] <= 8'd0;
         frame_ff[2] <= 8'd1;
         frame_ff[3] <= 8'd0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            cart_blocks_ff <= csr_write_data;
         end
         slot_kind_ff <= slot_kind_in;
         slot_blk_ff  <= slot_blk_in;
         frame_ff     <= frame_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      upd_reg_ff  <= upd_reg_in;
      upd_data_ff <= upd_data_in;
      if (accept) begin
         rsp_target_ff <= rsp_target_in;
         rsp_phys_ff   <= rsp_phys_in;
         rsp_we_ff     <= rsp_we_in;
         rsp_upd_ff    <= rsp_upd_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_target         = rsp_target_ff;
   assign rsp_phys_address   = rsp_phys_ff;
   assign rsp_write_enable   = rsp_we_ff;
   assign rsp_mapper_updated = rsp_upd_ff;

endmodule

FILE: rtl/bmm_checker.sv
// bmm_checker: port-level assertions on the mapper core, bound to the core module
// depends on bmm_pkg and banked_memory_mapper_core

module bmm_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_stall,
   input logic                        rsp_valid,
   input logic                        rsp_stall,
   input logic [bmm_pkg::TGT_W-1:0]   rsp_target,
   input logic [bmm_pkg::PHYS_W-1:0]  rsp_phys_address,
   input logic                        rsp_write_enable,
   input logic                        rsp_mapper_updated
);

   // a stalled response stays valid
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("response dropped while stalled");

   // every accepted request gives a response in the next cycle
   a_req_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request without response");

   // a frame register load only comes with a write to a target other than open bus
   a_upd_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_mapper_updated |-> rsp_write_enable
                                          && (rsp_target != bmm_pkg::TGT_OPEN))
      else $error("mapper update without write");

   // open bus carries address zero and is never written
   a_open_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_target == bmm_pkg::TGT_OPEN) |->
         (rsp_phys_address == '0) && !rsp_write_enable)
      else $error("open bus response with address or write");

endmodule

bind banked_memory_mapper_core bmm_checker u_bmm_checker (.*);
